// ===== hw/rtl/tcpq_pkg.sv =====
`timescale 1ns / 1ps

package tcpq_pkg;

    // Widest identifier and rank that any configuration of the block can use.
    localparam int unsigned IdW   = 16;
    localparam int unsigned RankW = 9;

    localparam logic [1:0] ACT_ADMIT  = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] SEV_MILD = 2'd2;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]     action;
        logic [IdW-1:0] entry_id;
        logic [1:0]     severity;
        logic [7:0]     age;
    } t_in;

    typedef struct packed {
        logic [1:0]     status;
        logic [7:0]     info_age;
        logic           head_valid;
        logic [IdW-1:0] head_id;
        logic [1:0]     head_severity;
    } t_out;

    // Command broadcast to every cell; key is valid for the whole transaction.
    typedef struct packed {
        logic [1:0]       op;
        logic [IdW-1:0]   key;
        logic [1:0]       sev;
        logic [7:0]       age;
        logic [RankW-1:0] rank;
    } t_cmd;

    // Scan packet that travels one cell per cycle along the row.
    typedef struct packed {
        logic             valid;
        logic             head_pass;
        logic             hit;
        logic [7:0]       hit_age;
        logic [RankW-1:0] hit_rank;
        logic             free_found;
        logic [RankW-1:0] count;
        logic             best_valid;
        logic [1:0]       best_class;
        logic [RankW-1:0] best_rank;
        logic [IdW-1:0]   best_id;
    } t_pkt;

endpackage

// ===== hw/rtl/three_class_priority_queue.sv =====
`timescale 1ns / 1ps
// Three-class priority queue: a keyed store of up to CAPACITY waiting entries.
// Input channel (i_valid / o_ready, payload i_data) carries one action per
// transaction: admit, query stored age, or remove by identifier. Output
// channel (o_valid / i_ready, payload o_data) returns exactly one result per
// action: a status, the queried age, and the head entry (oldest entry of the
// most severe non-empty class) as it stands after the action.
// Each slot lives in one cell of a row of CAPACITY cells. A scan packet walks
// the row one cell per cycle, first to look up the identifier and find a free
// slot, then, after the action is applied in the S_APPLY state, to select the head.
// One transaction is worked on at a time, taking both walks along the cell
// row, and o_ready is high only while the block is idle.
// A finished result sits in the output register; the next transaction is
// accepted while it waits. When the receiver stalls, the following result is
// held inside until the output register frees.
// Reset clears every slot's valid mark, leaving the queue empty.
module three_class_priority_queue #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned ID_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tcpq_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output tcpq_pkg::t_out  o_data
);

    localparam int unsigned KEY_W  = (ID_WIDTH < tcpq_pkg::IdW) ? ID_WIDTH : tcpq_pkg::IdW;
    localparam int unsigned RANK_W = $clog2(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]     r_state;
    logic [1:0]     r_act;
    tcpq_pkg::t_cmd r_cmd;
    tcpq_pkg::t_pkt r_inj;
    logic [1:0]     r_status;
    logic [7:0]     r_info;
    tcpq_pkg::t_out r_res;
    tcpq_pkg::t_out r_out;
    logic           r_out_valid;

    tcpq_pkg::t_pkt w_pkt [CAPACITY+1];
    tcpq_pkg::t_pkt w_last;
    logic           w_accept;
    logic           w_load_out;

    assign w_pkt[0]   = r_inj;
    assign w_last     = w_pkt[CAPACITY];
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            tcpq_cell #(
                .KEY_W  (KEY_W),
                .RANK_W (RANK_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (r_cmd),
                .i_pkt   (w_pkt[g]),
                .o_pkt   (w_pkt[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inj       <= '0;
            r_cmd.op    <= tcpq_pkg::CMD_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_inj <= '0;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_inj.valid <= 1'b1;
                        r_cmd.key   <= tcpq_pkg::IdW'(i_data.entry_id[KEY_W-1:0]);
                        r_cmd.sev   <= (i_data.severity > tcpq_pkg::SEV_MILD) ?
                                       tcpq_pkg::SEV_MILD : i_data.severity;
                        r_cmd.age   <= i_data.age;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_last.valid && !w_last.head_pass) begin
                        r_state    <= S_APPLY;
                        r_cmd.rank <= '0;
                        case (r_act)
                            tcpq_pkg::ACT_ADMIT: begin
                                if (!w_last.hit && w_last.free_found) begin
                                    r_cmd.op   <= tcpq_pkg::CMD_WRITE;
                                    r_cmd.rank <= w_last.count;
                                end
                            end
                            tcpq_pkg::ACT_REMOVE: begin
                                if (w_last.hit) begin
                                    r_cmd.op   <= tcpq_pkg::CMD_REMOVE;
                                    r_cmd.rank <= w_last.hit_rank;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_APPLY: begin
                    // cells apply the command at this edge; start the head walk behind it
                    r_cmd.op        <= tcpq_pkg::CMD_NONE;
                    r_inj.valid     <= 1'b1;
                    r_inj.head_pass <= 1'b1;
                    r_state         <= S_HEAD;
                end
                S_HEAD: begin
                    if (w_last.valid && w_last.head_pass) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_data.action;
        end
        if ((r_state == S_SCAN) && w_last.valid && !w_last.head_pass) begin
            r_status <= tcpq_pkg::ST_OK;
            r_info   <= '0;
            case (r_act)
                tcpq_pkg::ACT_ADMIT: begin
                    if (w_last.hit) begin
                        r_status <= tcpq_pkg::ST_DUPLICATE;
                    end else if (!w_last.free_found) begin
                        r_status <= tcpq_pkg::ST_FULL;
                    end
                end
                tcpq_pkg::ACT_QUERY: begin
                    if (w_last.hit) begin
                        r_info <= w_last.hit_age;
                    end else begin
                        r_status <= tcpq_pkg::ST_NOT_FOUND;
                    end
                end
                tcpq_pkg::ACT_REMOVE: begin
                    if (!w_last.hit) begin
                        r_status <= tcpq_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
        if ((r_state == S_HEAD) && w_last.valid && w_last.head_pass) begin
            r_res.status        <= r_status;
            r_res.info_age      <= r_info;
            r_res.head_valid    <= w_last.best_valid;
            r_res.head_id       <= w_last.best_id;
            r_res.head_severity <= w_last.best_class;
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/tcpq_cell.sv =====
`timescale 1ns / 1ps

module tcpq_cell #(
    parameter int unsigned KEY_W  = 16,
    parameter int unsigned RANK_W = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcpq_pkg::t_cmd  i_cmd,
    input  tcpq_pkg::t_pkt  i_pkt,
    output tcpq_pkg::t_pkt  o_pkt
);

    logic              r_valid;
    logic [KEY_W-1:0]  r_id;
    logic [1:0]        r_class;
    logic [7:0]        r_age;
    logic [RANK_W-1:0] r_rank;
    logic              r_hit;
    logic              r_free;
    tcpq_pkg::t_pkt    r_pkt;
    tcpq_pkg::t_pkt    n_pkt;

    logic                       w_match;
    logic                       w_is_free;
    logic                       w_better;
    logic [tcpq_pkg::RankW-1:0] w_rank_ext;

    assign w_rank_ext = tcpq_pkg::RankW'(r_rank);
    assign w_match    = r_valid && (r_id == i_cmd.key[KEY_W-1:0]);
    assign w_is_free  = !r_valid && !i_pkt.free_found;
    assign w_better   = r_valid && (!i_pkt.best_valid ||
                        (r_class < i_pkt.best_class) ||
                        ((r_class == i_pkt.best_class) && (w_rank_ext < i_pkt.best_rank)));

    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.valid && !i_pkt.head_pass) begin
            if (w_match) begin
                n_pkt.hit      = 1'b1;
                n_pkt.hit_age  = r_age;
                n_pkt.hit_rank = w_rank_ext;
            end
            if (r_valid) begin
                n_pkt.count = i_pkt.count + tcpq_pkg::RankW'(1);
            end else if (w_is_free) begin
                n_pkt.free_found = 1'b1;
            end
        end else if (i_pkt.valid && w_better) begin
            n_pkt.best_valid = 1'b1;
            n_pkt.best_class = r_class;
            n_pkt.best_rank  = w_rank_ext;
            n_pkt.best_id    = tcpq_pkg::IdW'(r_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_pkt     <= '0;
        end else begin
            r_pkt <= n_pkt;
            // latch this cell's role for the command that follows the search
            if (i_pkt.valid && !i_pkt.head_pass) begin
                r_hit  <= w_match;
                r_free <= w_is_free;
            end
            case (i_cmd.op)
                tcpq_pkg::CMD_WRITE: begin
                    if (r_free) begin
                        r_valid <= 1'b1;
                    end
                end
                tcpq_pkg::CMD_REMOVE: begin
                    if (r_hit) begin
                        r_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tcpq_pkg::CMD_WRITE: begin
                if (r_free) begin
                    r_id    <= i_cmd.key[KEY_W-1:0];
                    r_class <= i_cmd.sev;
                    r_age   <= i_cmd.age;
                    r_rank  <= i_cmd.rank[RANK_W-1:0];
                end
            end
            tcpq_pkg::CMD_REMOVE: begin
                // close the gap left by the removed entry
                if (r_valid && !r_hit && (r_rank > i_cmd.rank[RANK_W-1:0])) begin
                    r_rank <= r_rank - RANK_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pkt = r_pkt;

endmodule

// ===== sim/tb_three_class_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_three_class_priority_queue;

    localparam int CAP        = 16;
    localparam int IDW        = 16;
    localparam int LATENCY    = 2 * CAP + 5;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int RAND_ITEMS = 1600;
    localparam int POOL_SIZE  = 32;

    // Codes the package leaves unnamed.
    localparam logic [1:0] ACT_IDLE   = 2'd3;
    localparam logic [1:0] SEV_GRAVE  = 2'd0;
    localparam logic [1:0] SEV_NORMAL = 2'd1;
    localparam logic [1:0] SEV_UNUSED = 2'd3;

    typedef struct {
        tcpq_pkg::t_in  item;
        bit             typed;
        tcpq_pkg::t_out want;
    } t_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_ready = 1'b0;
    tcpq_pkg::t_in  i_data  = '0;
    logic           o_ready;
    logic           o_valid;
    tcpq_pkg::t_out o_data;

    // Shadow copy of the queue contents.
    bit              slot_used  [CAP];
    logic [IDW-1:0]  slot_id    [CAP];
    logic [1:0]      slot_class [CAP];
    logic [7:0]      slot_age   [CAP];
    int              slot_rank  [CAP];

    tcpq_pkg::t_out pending_results[$];
    t_row           directed_rows[$];
    logic [IDW-1:0] id_pool[POOL_SIZE];
    int             fail_count  = 0;
    int             cycle_count = 0;
    bit             steady      = 1'b0;

    three_class_priority_queue #(
        .CAPACITY(CAP),
        .ID_WIDTH(IDW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Apply one action to the shadow queue and return the result it produces.
    function automatic tcpq_pkg::t_out apply_action(input tcpq_pkg::t_in item);
        tcpq_pkg::t_out res;
        logic [1:0]     cls;
        int             hit;
        int             free_slot;
        int             count;
        int             best;
        int             gone;
        res       = '0;
        cls       = (item.severity > tcpq_pkg::SEV_MILD) ? tcpq_pkg::SEV_MILD : item.severity;
        hit       = -1;
        free_slot = -1;
        count     = 0;
        for (int k = 0; k < CAP; k++) begin
            if (slot_used[k] && slot_id[k] == item.entry_id)
                hit = k;
            if (slot_used[k])
                count++;
            else if (free_slot < 0)
                free_slot = k;
        end
        case (item.action)
            tcpq_pkg::ACT_ADMIT: begin
                if (hit >= 0) begin
                    res.status = tcpq_pkg::ST_DUPLICATE;
                end else if (free_slot < 0) begin
                    res.status = tcpq_pkg::ST_FULL;
                end else begin
                    slot_used[free_slot]  = 1'b1;
                    slot_id[free_slot]    = item.entry_id;
                    slot_class[free_slot] = cls;
                    slot_age[free_slot]   = item.age;
                    slot_rank[free_slot]  = count;
                end
            end
            tcpq_pkg::ACT_QUERY: begin
                if (hit < 0)
                    res.status = tcpq_pkg::ST_NOT_FOUND;
                else
                    res.info_age = slot_age[hit];
            end
            tcpq_pkg::ACT_REMOVE: begin
                if (hit < 0) begin
                    res.status = tcpq_pkg::ST_NOT_FOUND;
                end else begin
                    gone           = slot_rank[hit];
                    slot_used[hit] = 1'b0;
                    // Close the gap in the arrival order.
                    for (int k = 0; k < CAP; k++)
                        if (slot_used[k] && slot_rank[k] > gone)
                            slot_rank[k]--;
                end
            end
            default: ;
        endcase
        best = -1;
        for (int k = 0; k < CAP; k++) begin
            if (slot_used[k] && (best < 0 || slot_class[k] < slot_class[best] ||
                (slot_class[k] == slot_class[best] && slot_rank[k] < slot_rank[best])))
                best = k;
        end
        if (best >= 0) begin
            res.head_valid    = 1'b1;
            res.head_id       = slot_id[best];
            res.head_severity = slot_class[best];
        end
        return res;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [IDW-1:0] id,
                                    input logic [1:0] sev, input logic [7:0] age,
                                    input bit typed = 1'b0,
                                    input tcpq_pkg::t_out want = '0);
        t_row row;
        row.item  = '{action: act, entry_id: id, severity: sev, age: age};
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic int stored_count();
        int n;
        n = 0;
        for (int k = 0; k < CAP; k++)
            n += slot_used[k];
        return n;
    endfunction

    // Present one transaction, hold it until accepted, then log its result.
    task automatic send_item(input tcpq_pkg::t_in item, input bit typed,
                             input tcpq_pkg::t_out want);
        int             gap;
        tcpq_pkg::t_out res;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 37)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        res = apply_action(item);
        pending_results.push_back(typed ? want : res);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        tcpq_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status=%0d age=%0d head=%0b/%h/%0d",
                             o_data.status, o_data.info_age, o_data.head_valid,
                             o_data.head_id, o_data.head_severity);
            end else begin
                want = pending_results.pop_front();
                if (o_data.status !== want.status || o_data.info_age !== want.info_age ||
                    o_data.head_valid !== want.head_valid ||
                    o_data.head_id !== want.head_id ||
                    o_data.head_severity !== want.head_severity) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected status=%0d age=%0d head=%0b/%h/%0d",
                                 want.status, want.info_age, want.head_valid,
                                 want.head_id, want.head_severity);
                        $display("          got      status=%0d age=%0d head=%0b/%h/%0d",
                                 o_data.status, o_data.info_age, o_data.head_valid,
                                 o_data.head_id, o_data.head_severity);
                    end
                end
            end
        end
        i_ready <= steady || ($urandom_range(0, 99) >= 37);
    end

    initial begin
        tcpq_pkg::t_in item;
        int            admit_pct;
        int            pick;
        logic [1:0]    act;

        // Empty store, extremes, duplicate ahead of full, slot reuse.
        add_row(tcpq_pkg::ACT_QUERY, 16'hFFFF, SEV_GRAVE, 8'h00, 1'b1,
                tcpq_pkg::t_out'{tcpq_pkg::ST_NOT_FOUND, 8'd0, 1'b0, 16'h0000, 2'd0});
        add_row(tcpq_pkg::ACT_REMOVE, 16'h0000, SEV_GRAVE, 8'h00, 1'b1,
                tcpq_pkg::t_out'{tcpq_pkg::ST_NOT_FOUND, 8'd0, 1'b0, 16'h0000, 2'd0});
        add_row(ACT_IDLE, 16'hA5A5, SEV_UNUSED, 8'hFF, 1'b1,
                tcpq_pkg::t_out'{tcpq_pkg::ST_OK, 8'd0, 1'b0, 16'h0000, 2'd0});
        add_row(tcpq_pkg::ACT_ADMIT, 16'h0000, tcpq_pkg::SEV_MILD, 8'h00, 1'b1,
                tcpq_pkg::t_out'{tcpq_pkg::ST_OK, 8'd0, 1'b1, 16'h0000,
                                 tcpq_pkg::SEV_MILD});
        add_row(tcpq_pkg::ACT_ADMIT, 16'h0000, SEV_GRAVE, 8'h01, 1'b1,
                tcpq_pkg::t_out'{tcpq_pkg::ST_DUPLICATE, 8'd0, 1'b1, 16'h0000,
                                 tcpq_pkg::SEV_MILD});
        add_row(tcpq_pkg::ACT_ADMIT, 16'hFFFF, SEV_UNUSED, 8'hFF);
        add_row(tcpq_pkg::ACT_QUERY, 16'hFFFF, SEV_GRAVE, 8'h00, 1'b1,
                tcpq_pkg::t_out'{tcpq_pkg::ST_OK, 8'hFF, 1'b1, 16'h0000,
                                 tcpq_pkg::SEV_MILD});
        for (int k = 1; k <= CAP - 2; k++)
            add_row(tcpq_pkg::ACT_ADMIT, IDW'(16'h1111 * k), 2'(k % 4), 8'(k * 17));
        add_row(tcpq_pkg::ACT_ADMIT, 16'h1234, SEV_GRAVE, 8'h7F);
        add_row(tcpq_pkg::ACT_ADMIT, 16'h5555, SEV_NORMAL, 8'h80);
        add_row(tcpq_pkg::ACT_REMOVE, 16'h3333, SEV_GRAVE, 8'h00);
        add_row(tcpq_pkg::ACT_ADMIT, 16'h0F0F, SEV_NORMAL, 8'h80);
        add_row(tcpq_pkg::ACT_QUERY, 16'hBEEF, SEV_GRAVE, 8'h00);
        add_row(ACT_IDLE, 16'h0F0F, SEV_GRAVE, 8'h00);

        for (int k = 0; k < POOL_SIZE; k++)
            id_pool[k] = IDW'($urandom_range(0, 65535));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        drain_results();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 600 && n < 900);
            if (n == 1000)
                drain_results();
            // Cycle the admit share so the store swings between empty and full.
            case ((n / 200) % 3)
                0:       admit_pct = 25;
                1:       admit_pct = 50;
                default: admit_pct = 75;
            endcase
            if (stored_count() == 0 && $urandom_range(0, 3) != 0)
                admit_pct = 90;
            pick = $urandom_range(0, 99);
            if (pick < admit_pct)
                act = tcpq_pkg::ACT_ADMIT;
            else if (pick < admit_pct + 4)
                act = ACT_IDLE;
            else if ($urandom_range(0, 2) == 0)
                act = tcpq_pkg::ACT_QUERY;
            else
                act = tcpq_pkg::ACT_REMOVE;
            item.action   = act;
            item.entry_id = ($urandom_range(0, 99) < 85) ?
                            id_pool[$urandom_range(0, POOL_SIZE - 1)] :
                            IDW'($urandom_range(0, 65535));
            item.severity = 2'($urandom_range(0, 3));
            item.age      = 8'($urandom_range(0, 255));
            send_item(item, 1'b0, tcpq_pkg::t_out'('0));
        end
        steady = 1'b0;

        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_cell.sv
hw/rtl/three_class_priority_queue.sv
sim/tb_three_class_priority_queue.sv
